### src/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 package
// Round constants, initial chaining values and rotate helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

    localparam int NUM_WORDS  = 5;
    localparam int BLK_WORDS  = 16;
    localparam int NUM_ROUNDS = 80;

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] t_word;

    localparam t_word H_INIT [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    function automatic t_word rotl1(input t_word x);
        return {x[30:0], x[31]};
    endfunction

    function automatic t_word rotl5(input t_word x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic t_word rotl30(input t_word x);
        return {x[1:0], x[31:2]};
    endfunction

endpackage

`default_nettype wire

### src/sha1_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Byte-serial SHA-1 with one compression round per cycle and a shifting
// 16-word message schedule.
// ----------------------------------------------------------------------------
// Each byte is stored in the idle state; a byte that fills a block starts
// 80 rounds on the single shared round unit, then one chaining add.
// End item: one pad step, then one or two final blocks (a second one after
// a length-load step), then five digest transfers.
// No new byte is accepted while a block is hashed or the digest is sent.
// Reset: synchronous, active low; chaining words reload h0 to h4.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hasher_unit
    import sha1_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_word_index,
    output logic [31:0]      o_digest_word,
    output logic             o_last_word
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_LEN   = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);
    localparam logic [2:0] LAST_IDX   = 3'(NUM_WORDS - 1);

    logic [2:0]  r_state;
    logic [2:0]  r_ret;
    logic [6:0]  r_round;
    logic [5:0]  r_fill;
    logic [60:0] r_msg;
    logic [2:0]  r_oidx;
    t_word       r_chain [NUM_WORDS];
    t_word       r_a, r_b, r_c, r_d, r_e;
    t_word       r_w [BLK_WORDS];

    t_word       n_a;
    t_word       n_sched;
    t_word       f_val;
    t_word       k_val;
    logic [63:0] bit_len;
    logic        accept_in;
    logic        blk_full;

    assign accept_in = i_valid && o_ready;
    assign blk_full  = i_has_byte && (r_fill == 6'd63);
    assign bit_len   = {r_msg, 3'b000};

    always_comb begin
        priority if (r_round < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K_R0;
        end else if (r_round < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_R1;
        end else if (r_round < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_R2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_R3;
        end
    end

    assign n_a     = rotl5(r_a) + f_val + r_e + k_val + r_w[0];
    assign n_sched = rotl1(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_round <= '0;
            r_fill  <= '0;
            r_msg   <= '0;
            r_oidx  <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_c     <= '0;
            r_d     <= '0;
            r_e     <= '0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_chain[i] <= H_INIT[i];
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept_in) begin
                        if (i_has_byte) begin
                            unique case (r_fill[1:0])
                                2'd0: r_w[r_fill[5:2]]        <= {i_data_byte, 24'h0};
                                2'd1: r_w[r_fill[5:2]][23:16] <= i_data_byte;
                                2'd2: r_w[r_fill[5:2]][15:8]  <= i_data_byte;
                                2'd3: r_w[r_fill[5:2]][7:0]   <= i_data_byte;
                            endcase
                            r_fill <= r_fill + 6'd1;
                            r_msg  <= r_msg + 61'd1;
                        end
                        if (blk_full) begin
                            r_state <= S_ROUND;
                            r_ret   <= i_last_byte ? S_PAD : S_IDLE;
                            r_round <= '0;
                            r_a <= r_chain[0];
                            r_b <= r_chain[1];
                            r_c <= r_chain[2];
                            r_d <= r_chain[3];
                            r_e <= r_chain[4];
                        end else if (i_last_byte) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    unique case (r_fill[1:0])
                        2'd0: r_w[r_fill[5:2]] <= {PAD_BYTE, 24'h0};
                        2'd1: r_w[r_fill[5:2]][23:0] <= {PAD_BYTE, 16'h0};
                        2'd2: r_w[r_fill[5:2]][15:0] <= {PAD_BYTE, 8'h0};
                        2'd3: r_w[r_fill[5:2]][7:0]  <= PAD_BYTE;
                    endcase
                    for (int j = 0; j < BLK_WORDS; j++) begin
                        if (4'(j) > r_fill[5:2]) begin
                            r_w[j] <= '0;
                        end
                    end
                    if (r_fill[5:3] == 3'b111) begin
                        r_ret <= S_LEN;
                    end else begin
                        r_ret <= S_OUT;
                        r_w[BLK_WORDS-2] <= bit_len[63:32];
                        r_w[BLK_WORDS-1] <= bit_len[31:0];
                    end
                    r_fill  <= '0;
                    r_state <= S_ROUND;
                    r_round <= '0;
                    r_a <= r_chain[0];
                    r_b <= r_chain[1];
                    r_c <= r_chain[2];
                    r_d <= r_chain[3];
                    r_e <= r_chain[4];
                end
                S_LEN: begin
                    for (int j = 0; j < BLK_WORDS - 2; j++) begin
                        r_w[j] <= '0;
                    end
                    r_w[BLK_WORDS-2] <= bit_len[63:32];
                    r_w[BLK_WORDS-1] <= bit_len[31:0];
                    r_ret   <= S_OUT;
                    r_state <= S_ROUND;
                    r_round <= '0;
                    r_a <= r_chain[0];
                    r_b <= r_chain[1];
                    r_c <= r_chain[2];
                    r_d <= r_chain[3];
                    r_e <= r_chain[4];
                end
                S_ROUND: begin
                    r_a <= n_a;
                    r_b <= r_a;
                    r_c <= rotl30(r_b);
                    r_d <= r_c;
                    r_e <= r_d;
                    for (int j = 0; j < BLK_WORDS - 1; j++) begin
                        r_w[j] <= r_w[j+1];
                    end
                    r_w[BLK_WORDS-1] <= n_sched;
                    r_round <= r_round + 7'd1;
                    if (r_round == LAST_ROUND) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_chain[4] <= r_chain[4] + r_e;
                    r_round <= '0;
                    r_state <= r_ret;
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (r_oidx == LAST_IDX) begin
                            r_oidx  <= '0;
                            r_msg   <= '0;
                            r_state <= S_IDLE;
                            for (int i = 0; i < NUM_WORDS; i++) begin
                                r_chain[i] <= H_INIT[i];
                            end
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_word_index  = r_oidx;
    assign o_digest_word = r_chain[r_oidx];
    assign o_last_word   = (r_oidx == LAST_IDX);

endmodule

`default_nettype wire

### src/sha1_checker.sv
// ----------------------------------------------------------------------------
// SHA-1 port checker
// Port-level checks on the digest transfer sequence, bound to the stream hasher unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_checker
    import sha1_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  o_word_index,
    input wire logic [31:0] o_digest_word,
    input wire logic        o_last_word
);

    localparam logic [2:0] LAST_IDX = 3'(NUM_WORDS - 1);

    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while digest is pending");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_word) |-> (o_word_index == LAST_IDX))
        else $error("last word flag on wrong index");

    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_word) |=>
            (o_valid && o_word_index == 3'($past(o_word_index) + 3'd1)))
        else $error("digest words not in sequence");

    a_end_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_word) |=> !o_valid)
        else $error("extra digest transfer after last word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_word_index) && $stable(o_digest_word)))
        else $error("stalled digest word changed");

endmodule

bind sha1_stream_hasher_unit sha1_checker u_sha1_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_word_index  (o_word_index),
    .o_digest_word (o_digest_word),
    .o_last_word   (o_last_word)
);

`default_nettype wire
